/* rtl/btkw_pkg.sv */
// shared types, constants and helpers of the bitmap trie key walker
package btkw_pkg;

  localparam int NODES    = 4096;
  localparam int CHILDREN = 256;
  localparam int MAX_KEY  = 255;

  localparam int NODE_W       = 12;
  localparam int WORD_W       = 32;
  localparam int WSEL_W       = 3;
  localparam int WORDS        = 1 << WSEL_W;
  localparam int BIT_W        = 5;
  localparam int BM_ADDR_W    = NODE_W + WSEL_W;
  localparam int BM_DEPTH     = 1 << BM_ADDR_W;
  localparam int BASE_DEPTH   = 1 << NODE_W;
  localparam int BASE_W       = NODE_W + 1;
  localparam int SUM_W        = 9;
  localparam int ISSUE_W      = WSEL_W + 1;
  localparam int LIM_W        = 17;

  localparam logic [LIM_W-1:0]  NODES_LIM    = LIM_W'(NODES);
  localparam logic [8:0]        CHILDREN_LIM = 9'(CHILDREN);
  localparam logic [7:0]        MAX_KEY_CNT  = 8'(MAX_KEY);
  localparam logic [NODE_W:0]   NODE_MAX     = {1'b0, {NODE_W{1'b1}}};

  typedef enum logic [1:0] {
    OP_LOAD_BITMAP = 2'd0,
    OP_LOAD_BASE   = 2'd1,
    OP_START       = 2'd2,
    OP_KEY         = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_SCAN,
    S_CHECK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [NODE_W-1:0] load_node;
    logic [WSEL_W-1:0] word_select;
    logic [WORD_W-1:0] bitmap_word;
    logic [NODE_W-1:0] child_base;
    logic              base_is_terminal;
    logic [7:0]        key_byte;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic              failed;
    logic [NODE_W-1:0] current_node_out;
    logic              current_terminal_out;
    logic [7:0]        key_length;
  } out_item_t;

  typedef struct packed {
    logic                 we;
    logic [BM_ADDR_W-1:0] addr;
    logic [WORD_W-1:0]    data;
  } bm_wr_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] addr;
    logic [BASE_W-1:0] data;
  } base_wr_t;

  typedef struct packed {
    logic clr;
    logic en;
    logic last;
  } acc_ctl_t;

  function automatic logic [5:0] popcount32(input logic [WORD_W-1:0] v);
    logic [5:0] n;
    logic [2:0] nib;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      nib = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
      n = n + 6'(nib);
    end
    return n;
  endfunction

endpackage

/* rtl/btkw_store.sv */
// bitmap word memory and child base memory, one write and one registered read each
module btkw_store (
  input  logic                          clk_i,
  input  btkw_pkg::bm_wr_t              bm_wr_i,
  input  logic [btkw_pkg::BM_ADDR_W-1:0] bm_raddr_i,
  output logic [btkw_pkg::WORD_W-1:0]   bm_rdata_o,
  input  btkw_pkg::base_wr_t            base_wr_i,
  input  logic [btkw_pkg::NODE_W-1:0]   base_raddr_i,
  output logic [btkw_pkg::BASE_W-1:0]   base_rdata_o
);

  logic [btkw_pkg::WORD_W-1:0] bm_mem   [btkw_pkg::BM_DEPTH];
  logic [btkw_pkg::BASE_W-1:0] base_mem [btkw_pkg::BASE_DEPTH];
  logic [btkw_pkg::WORD_W-1:0] bm_rdata_q;
  logic [btkw_pkg::BASE_W-1:0] base_rdata_q;

  always_ff @(posedge clk_i) begin
    if (bm_wr_i.we) begin
      bm_mem[bm_wr_i.addr] <= bm_wr_i.data;
    end
    bm_rdata_q <= bm_mem[bm_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (base_wr_i.we) begin
      base_mem[base_wr_i.addr] <= base_wr_i.data;
    end
    base_rdata_q <= base_mem[base_raddr_i];
  end

  assign bm_rdata_o   = bm_rdata_q;
  assign base_rdata_o = base_rdata_q;

endmodule

/* rtl/btkw_accum.sv */
// popcount and accumulate unit, one bitmap word per cycle while enabled
module btkw_accum (
  input  logic                          clk_i,
  input  btkw_pkg::acc_ctl_t            ctl_i,
  input  logic [btkw_pkg::BIT_W-1:0]    bit_sel_i,
  input  logic [btkw_pkg::WORD_W-1:0]   data_i,
  output logic [btkw_pkg::SUM_W-1:0]    sum_o,
  output logic                          hit_o
);

  logic [btkw_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic                        hit_q, hit_d;
  logic [btkw_pkg::WORD_W-1:0] mask;
  logic [btkw_pkg::WORD_W-1:0] masked;

  always_comb begin
    // only bits below the key bit count in the last word
    mask   = ~({btkw_pkg::WORD_W{1'b1}} << bit_sel_i);
    masked = ctl_i.last ? (data_i & mask) : data_i;
    sum_d  = sum_q;
    hit_d  = hit_q;
    if (ctl_i.clr) begin
      sum_d = '0;
      hit_d = 1'b0;
    end else if (ctl_i.en) begin
      sum_d = sum_q + btkw_pkg::SUM_W'(btkw_pkg::popcount32(masked));
      if (ctl_i.last) begin
        hit_d = data_i[bit_sel_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    hit_q <= hit_d;
  end

  assign sum_o = sum_q;
  assign hit_o = hit_q;

endmodule

/* rtl/bitmap_trie_key_walker.sv */
// top level of the bitmap trie key walker: sequencer, walk state and result register
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o  | in_item_i  (btkw_pkg::in_item_t)
//  out     | output    | out_valid_o / out_ready_i| out_item_o (btkw_pkg::out_item_t)
//
// a load or start goes through the done state to the output register, a key byte through
// walk, scan, check and done; the scan reads words 0 up to the key's word, one word per cycle.
// a key byte that fails before the scan (failed walk, terminal node) goes from walk to done.
// one item is in work at a time; in_ready_o is high only in idle.
// a new item is taken while the last result still waits in the output register.
// rst_ni clears the walk state and the output valid; the memories are not cleared.
module bitmap_trie_key_walker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  btkw_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output btkw_pkg::out_item_t out_item_o
);

  btkw_pkg::state_e state_q, state_d;

  logic [btkw_pkg::NODE_W-1:0]  cur_node_q, cur_node_d;
  logic                         cur_term_q, cur_term_d;
  logic                         failed_q, failed_d;
  logic [7:0]                   key_cnt_q, key_cnt_d;
  logic                         found_q, found_d;
  logic [btkw_pkg::ISSUE_W-1:0] issue_cnt_q, issue_cnt_d;
  logic                         data_vld_q, data_vld_d;
  logic [btkw_pkg::WSEL_W-1:0]  data_idx_q, data_idx_d;
  logic                         out_valid_q, out_valid_d;
  btkw_pkg::out_item_t          out_item_q, out_item_d;
  logic [7:0]                   kb_q;

  btkw_pkg::bm_wr_t             bm_wr;
  btkw_pkg::base_wr_t           base_wr;
  logic [btkw_pkg::BM_ADDR_W-1:0] bm_raddr;
  logic [btkw_pkg::WORD_W-1:0]  bm_rdata;
  logic [btkw_pkg::BASE_W-1:0]  base_rdata;
  btkw_pkg::acc_ctl_t           acc_ctl;
  logic [btkw_pkg::SUM_W-1:0]   acc_sum;
  logic                         acc_hit;

  logic                         in_xfer;
  logic                         node_ok;
  logic [btkw_pkg::WSEL_W-1:0]  key_word;
  logic [btkw_pkg::NODE_W:0]    child_idx;

  assign in_ready_o = (state_q == btkw_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign node_ok    = {5'd0, in_item_i.load_node} < btkw_pkg::NODES_LIM;
  assign key_word   = kb_q[7:btkw_pkg::BIT_W];
  assign bm_raddr   = {cur_node_q, issue_cnt_q[btkw_pkg::WSEL_W-1:0]};
  assign child_idx  = {1'b0, base_rdata[btkw_pkg::NODE_W-1:0]}
                    + (btkw_pkg::NODE_W+1)'(acc_sum);

  btkw_store u_store (
    .clk_i        (clk_i),
    .bm_wr_i      (bm_wr),
    .bm_raddr_i   (bm_raddr),
    .bm_rdata_o   (bm_rdata),
    .base_wr_i    (base_wr),
    .base_raddr_i (cur_node_q),
    .base_rdata_o (base_rdata)
  );

  btkw_accum u_accum (
    .clk_i     (clk_i),
    .ctl_i     (acc_ctl),
    .bit_sel_i (kb_q[btkw_pkg::BIT_W-1:0]),
    .data_i    (bm_rdata),
    .sum_o     (acc_sum),
    .hit_o     (acc_hit)
  );

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kb_q <= in_item_i.key_byte;
    end
    out_item_q <= out_item_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= btkw_pkg::S_IDLE;
      cur_node_q  <= '0;
      cur_term_q  <= 1'b0;
      failed_q    <= 1'b0;
      key_cnt_q   <= '0;
      found_q     <= 1'b0;
      issue_cnt_q <= '0;
      data_vld_q  <= 1'b0;
      data_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_node_q  <= cur_node_d;
      cur_term_q  <= cur_term_d;
      failed_q    <= failed_d;
      key_cnt_q   <= key_cnt_d;
      found_q     <= found_d;
      issue_cnt_q <= issue_cnt_d;
      data_vld_q  <= data_vld_d;
      data_idx_q  <= data_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cur_node_d  = cur_node_q;
    cur_term_d  = cur_term_q;
    failed_d    = failed_q;
    key_cnt_d   = key_cnt_q;
    found_d     = found_q;
    issue_cnt_d = issue_cnt_q;
    data_vld_d  = 1'b0;
    data_idx_d  = data_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    acc_ctl     = '0;

    bm_wr.we      = 1'b0;
    bm_wr.addr    = {in_item_i.load_node, in_item_i.word_select};
    bm_wr.data    = in_item_i.bitmap_word;
    base_wr.we    = 1'b0;
    base_wr.addr  = in_item_i.load_node;
    base_wr.data  = {in_item_i.base_is_terminal, in_item_i.child_base};

    case (state_q)
      btkw_pkg::S_IDLE: begin
        if (in_xfer) begin
          found_d = 1'b0;
          state_d = btkw_pkg::S_DONE;
          case (in_item_i.opcode)
            btkw_pkg::OP_LOAD_BITMAP: bm_wr.we   = node_ok;
            btkw_pkg::OP_LOAD_BASE:   base_wr.we = node_ok;
            btkw_pkg::OP_START: begin
              cur_node_d = '0;
              cur_term_d = 1'b0;
              failed_d   = 1'b0;
              key_cnt_d  = '0;
            end
            btkw_pkg::OP_KEY:         state_d = btkw_pkg::S_WALK;
            default:                  state_d = btkw_pkg::S_DONE;
          endcase
        end
      end
      btkw_pkg::S_WALK: begin
        if (failed_q) begin
          state_d = btkw_pkg::S_DONE;
        end else if (cur_term_q || ({1'b0, kb_q} >= btkw_pkg::CHILDREN_LIM)
                     || ({5'd0, cur_node_q} >= btkw_pkg::NODES_LIM)) begin
          failed_d   = 1'b1;
          cur_node_d = '0;
          cur_term_d = 1'b0;
          state_d    = btkw_pkg::S_DONE;
        end else begin
          issue_cnt_d = '0;
          acc_ctl.clr = 1'b1;
          state_d     = btkw_pkg::S_SCAN;
        end
      end
      btkw_pkg::S_SCAN: begin
        // reads of words 0..key_word overlap with accumulation of the previous word
        if (issue_cnt_q <= {1'b0, key_word}) begin
          data_vld_d  = 1'b1;
          data_idx_d  = issue_cnt_q[btkw_pkg::WSEL_W-1:0];
          issue_cnt_d = issue_cnt_q + 1'b1;
        end
        if (data_vld_q) begin
          acc_ctl.en   = 1'b1;
          acc_ctl.last = (data_idx_q == key_word);
          if (data_idx_q == key_word) begin
            state_d = btkw_pkg::S_CHECK;
          end
        end
      end
      btkw_pkg::S_CHECK: begin
        state_d = btkw_pkg::S_DONE;
        if (!acc_hit || (child_idx > btkw_pkg::NODE_MAX)
            || ({4'd0, child_idx} >= btkw_pkg::NODES_LIM)) begin
          failed_d   = 1'b1;
          cur_node_d = '0;
          cur_term_d = 1'b0;
        end else begin
          found_d    = 1'b1;
          cur_node_d = child_idx[btkw_pkg::NODE_W-1:0];
          cur_term_d = base_rdata[btkw_pkg::NODE_W];
          if (key_cnt_q < btkw_pkg::MAX_KEY_CNT) begin
            key_cnt_d = key_cnt_q + 8'd1;
          end
        end
      end
      btkw_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d                     = 1'b1;
          out_item_d.found                = found_q;
          out_item_d.failed               = failed_q;
          out_item_d.current_node_out     = cur_node_q;
          out_item_d.current_terminal_out = cur_term_q;
          out_item_d.key_length           = key_cnt_q;
          state_d                         = btkw_pkg::S_IDLE;
        end
      end
      default: state_d = btkw_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* rtl/btkw_checker.sv */
// port-level checker of the bitmap trie key walker and its bind
module btkw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input btkw_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input btkw_pkg::out_item_t out_item_o
);

  // an offered item waits unchanged until it is taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i))
    else $error("input changed while waiting");

  // a result held back by the consumer stays as it is
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_found_not_failed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.found |-> !out_item_o.failed)
    else $error("found and failed together");

  // a failed walk parks at the null node
  a_failed_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.failed
      |-> (out_item_o.current_node_out == '0) && !out_item_o.current_terminal_out)
    else $error("failed walk not at null node");

  a_found_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.found |-> out_item_o.key_length != 8'd0)
    else $error("found with zero key length");

endmodule

bind bitmap_trie_key_walker btkw_checker u_btkw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
